// ===== rtl/barometric_sensor_compensation_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// Shorthand for clocked implication checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH

// same-cycle implication
`define BSC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bsc: same-cycle check failed");

// next-cycle implication
`define BSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bsc: next-cycle check failed");

`endif

// ===== rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, constants and helper functions shared by the compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CAL_T1_T2 = 3'd0,
        CAL_T3_P1 = 3'd1,
        CAL_P2_P3 = 3'd2,
        CAL_P4_P5 = 3'd3,
        CAL_P6_P7 = 3'd4,
        CAL_P8_P9 = 3'd5
    } t_cal_idx;

    localparam logic signed [14:0] TEMP_MIN    = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX    = 15'sd8500;
    localparam logic signed [31:0] T_FINE_OFS  = 32'sd128000;
    localparam logic        [20:0] P_FULL      = 21'd1048576;
    localparam logic        [63:0] DIVISOR_OFS = 64'h0000_8000_0000_0000;
    localparam logic signed [16:0] K_3125      = 17'sd3125;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } t_in;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic        [31:0] pressure_q24_8;
        logic               pressure_valid;
    } t_out;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_cal;

    // temperature results that ride along with the pressure path
    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic signed [31:0] fine_temperature;
    } t_side;

    typedef struct packed {
        logic [63:0] nq;    // numerator bits shift out, quotient bits shift in
        logic [30:0] rem;
        logic [30:0] ud;
        logic        neg;
        logic        zero;
        t_side       side;
    } t_div;

    function automatic logic signed [16:0] k17(input logic signed [15:0] k);
        return {k[15], k};
    endfunction

    // one 32-bit slice of a 64-bit word times a signed 17-bit coefficient
    function automatic logic signed [49:0] mul_pp(input logic [31:0] x,
                                                  input logic signed [16:0] k);
        return $signed({1'b0, x}) * k;
    endfunction

    // low 64 bits of the full product from its two slice products
    function automatic logic [63:0] pp_join(input logic signed [49:0] lo,
                                            input logic signed [49:0] hi);
        return {{14{lo[49]}}, lo} + {hi[31:0], 32'd0};
    endfunction

endpackage

// ===== rtl/bsc_temp.sv =====
// ----------------------------------------------------------------------------
// bsc_temp
// Four-stage temperature path: fine temperature, saturated centidegrees.
// ----------------------------------------------------------------------------
module bsc_temp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  bsc_pkg::t_in       i_data,
    input  bsc_pkg::t_cal      i_cal,
    output logic               o_valid,
    output bsc_pkg::t_side     o_side,
    output logic signed [31:0] o_a0,
    output logic        [19:0] o_raw_p
);
    import bsc_pkg::*;

    logic [3:0] r_vld;

    logic signed [18:0] w_d1;
    logic signed [17:0] w_d2;
    logic signed [34:0] r_v1p;
    logic signed [35:0] r_d2sq;
    logic        [19:0] r1_raw_p;

    logic signed [23:0] w_sq12;
    logic signed [23:0] r_v1;
    logic signed [39:0] r_v2p;
    logic        [19:0] r2_raw_p;

    logic signed [31:0] r_tf;
    logic        [19:0] r3_raw_p;

    logic signed [34:0] w_t5;
    logic signed [34:0] w_tcs;
    logic signed [14:0] w_tc;
    logic signed [14:0] r_tc;
    logic signed [31:0] r4_tf;
    logic signed [31:0] r_a0;
    logic        [19:0] r4_raw_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign w_d1 = $signed({2'b00, i_data.raw_temperature[19:3]})
                - $signed({2'b00, i_cal.t1, 1'b0});
    assign w_d2 = $signed({2'b00, i_data.raw_temperature[19:4]})
                - $signed({2'b00, i_cal.t1});

    assign w_sq12 = 24'(r_d2sq >>> 12);

    assign w_t5  = (35'(r_tf) <<< 2) + 35'(r_tf) + 35'sd128;
    assign w_tcs = w_t5 >>> 8;

    always_comb begin
        priority if (w_tcs < TEMP_MIN) begin
            w_tc = TEMP_MIN;
        end else if (w_tcs > TEMP_MAX) begin
            w_tc = TEMP_MAX;
        end else begin
            w_tc = w_tcs[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_v1p    <= w_d1 * i_cal.t2;
            r_d2sq   <= w_d2 * w_d2;
            r1_raw_p <= i_data.raw_pressure;

            r_v1     <= 24'(r_v1p >>> 11);
            r_v2p    <= w_sq12 * i_cal.t3;
            r2_raw_p <= r1_raw_p;

            r_tf     <= 32'(r_v1) + 32'(r_v2p >>> 14);
            r3_raw_p <= r2_raw_p;

            r_tc     <= w_tc;
            r4_tf    <= r_tf;
            r_a0     <= r_tf - T_FINE_OFS;
            r4_raw_p <= r3_raw_p;
        end
    end

    assign o_valid                  = r_vld[3];
    assign o_side.temperature_centi = r_tc;
    assign o_side.fine_temperature  = r4_tf;
    assign o_a0                     = r_a0;
    assign o_raw_p                  = r4_raw_p;

endmodule

// ===== rtl/bsc_coef.sv =====
// ----------------------------------------------------------------------------
// bsc_coef
// Seven-stage path that builds the pressure dividend and divisor from the
// fine temperature, the raw pressure and the pressure coefficients.
// ----------------------------------------------------------------------------
module bsc_coef (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  bsc_pkg::t_side     i_side,
    input  logic signed [31:0] i_a0,
    input  logic        [19:0] i_raw_p,
    input  bsc_pkg::t_cal      i_cal,
    output logic               o_valid,
    output bsc_pkg::t_side     o_side,
    output logic        [63:0] o_num,
    output logic signed [30:0] o_den
);
    import bsc_pkg::*;

    logic [6:0] r_vld;
    t_side r1_side, r2_side, r3_side, r4_side, r5_side, r6_side, r7_side;

    logic signed [63:0] r1_aa;
    logic signed [47:0] r1_ap5, r1_ap2;
    logic        [20:0] r1_pn;

    logic signed [49:0] r2_pp6l, r2_pp6h, r2_pp3l, r2_pp3h;
    logic signed [47:0] r2_ap5, r2_ap2;
    logic        [20:0] r2_pn;

    logic        [63:0] r3_aap6, r3_aap3;
    logic signed [47:0] r3_ap5, r3_ap2;
    logic        [20:0] r3_pn;

    logic signed [63:0] w_aap3s, w_ap2x, w_ap5x, w_p4x;
    logic        [63:0] r4_b, r4_a2;
    logic        [20:0] r4_pn;

    logic        [63:0] w_x;
    logic signed [49:0] r5_ppxl, r5_ppxh;
    logic        [63:0] r5_num0;

    logic        [63:0] w_xp;
    logic signed [30:0] r6_a3;
    logic signed [49:0] r6_ppnl, r6_ppnh;

    logic        [63:0] r7_num;
    logic signed [30:0] r7_a3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    assign w_aap3s = $signed(r3_aap3) >>> 8;
    assign w_ap2x  = 64'(r3_ap2) <<< 12;
    assign w_ap5x  = 64'(r3_ap5) <<< 17;
    assign w_p4x   = 64'(i_cal.p4) <<< 35;

    assign w_x  = r4_a2 + DIVISOR_OFS;
    assign w_xp = pp_join(r5_ppxl, r5_ppxh);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // stage 1: squares and first products of the temperature offset
            r1_aa   <= i_a0 * i_a0;
            r1_ap5  <= i_a0 * i_cal.p5;
            r1_ap2  <= i_a0 * i_cal.p2;
            r1_pn   <= P_FULL - {1'b0, i_raw_p};
            r1_side <= i_side;

            // stage 2: split products of the square
            r2_pp6l <= mul_pp(r1_aa[31:0], k17(i_cal.p6));
            r2_pp6h <= mul_pp(r1_aa[63:32], k17(i_cal.p6));
            r2_pp3l <= mul_pp(r1_aa[31:0], k17(i_cal.p3));
            r2_pp3h <= mul_pp(r1_aa[63:32], k17(i_cal.p3));
            r2_ap5  <= r1_ap5;
            r2_ap2  <= r1_ap2;
            r2_pn   <= r1_pn;
            r2_side <= r1_side;

            r3_aap6 <= pp_join(r2_pp6l, r2_pp6h);
            r3_aap3 <= pp_join(r2_pp3l, r2_pp3h);
            r3_ap5  <= r2_ap5;
            r3_ap2  <= r2_ap2;
            r3_pn   <= r2_pn;
            r3_side <= r2_side;

            r4_b    <= r3_aap6 + w_ap5x + w_p4x;
            r4_a2   <= w_aap3s + w_ap2x;
            r4_pn   <= r3_pn;
            r4_side <= r3_side;

            r5_ppxl <= mul_pp(w_x[31:0], {1'b0, i_cal.p1});
            r5_ppxh <= mul_pp(w_x[63:32], {1'b0, i_cal.p1});
            r5_num0 <= {12'd0, r4_pn, 31'd0} - r4_b;
            r5_side <= r4_side;

            r6_a3   <= w_xp[63:33];
            r6_ppnl <= mul_pp(r5_num0[31:0], K_3125);
            r6_ppnh <= mul_pp(r5_num0[63:32], K_3125);
            r6_side <= r5_side;

            r7_num  <= pp_join(r6_ppnl, r6_ppnh);
            r7_a3   <= r6_a3;
            r7_side <= r6_side;
        end
    end

    assign o_valid = r_vld[6];
    assign o_side  = r7_side;
    assign o_num   = r7_num;
    assign o_den   = r7_a3;

endmodule

// ===== rtl/bsc_div.sv =====
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined signed truncating divider: sign split, one quotient bit per
// stage over 64 stages, sign restore.
// ----------------------------------------------------------------------------
module bsc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  bsc_pkg::t_side     i_side,
    input  logic        [63:0] i_num,
    input  logic signed [30:0] i_den,
    output logic               o_valid,
    output bsc_pkg::t_side     o_side,
    output logic        [63:0] o_quot,
    output logic               o_zero
);
    import bsc_pkg::*;

    t_div w_st  [0:DIV_STEPS];
    logic w_vld [0:DIV_STEPS];

    t_div r_front;
    logic r_front_vld;

    logic [63:0] r_quot;
    logic        r_zero;
    t_side       r_side;
    logic        r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_vld <= 1'b0;
        end else if (i_adv) begin
            r_front_vld <= i_valid;
        end
    end

    // split off the signs and start with an empty remainder
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_front.nq   <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_front.ud   <= i_den[30] ? (31'd0 - i_den) : i_den;
            r_front.rem  <= '0;
            r_front.neg  <= i_num[63] ^ i_den[30];
            r_front.zero <= (i_den == '0);
            r_front.side <= i_side;
        end
    end

    assign w_st[0]  = r_front;
    assign w_vld[0] = r_front_vld;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        logic [31:0] w_trial;
        logic        w_ge;
        t_div        r_st;
        logic        r_vld;

        assign w_trial = {w_st[i].rem, w_st[i].nq[63]};
        assign w_ge    = (w_trial >= {1'b0, w_st[i].ud});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_adv) begin
                r_vld <= w_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st.nq   <= {w_st[i].nq[62:0], w_ge};
                r_st.rem  <= w_ge ? 31'(w_trial - {1'b0, w_st[i].ud}) : w_trial[30:0];
                r_st.ud   <= w_st[i].ud;
                r_st.neg  <= w_st[i].neg;
                r_st.zero <= w_st[i].zero;
                r_st.side <= w_st[i].side;
            end
        end

        assign w_st[i+1]  = r_st;
        assign w_vld[i+1] = r_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_adv) begin
            r_out_vld <= w_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_quot <= w_st[DIV_STEPS].neg ? (64'd0 - w_st[DIV_STEPS].nq)
                                          : w_st[DIV_STEPS].nq;
            r_zero <= w_st[DIV_STEPS].zero;
            r_side <= w_st[DIV_STEPS].side;
        end
    end

    assign o_valid = r_out_vld;
    assign o_side  = r_side;
    assign o_quot  = r_quot;
    assign o_zero  = r_zero;

endmodule

// ===== rtl/bsc_post.sv =====
// ----------------------------------------------------------------------------
// bsc_post
// Six-stage pressure correction after the divide, result word assembly.
// ----------------------------------------------------------------------------
module bsc_post (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  bsc_pkg::t_side i_side,
    input  logic    [63:0] i_quot,
    input  logic           i_zero,
    input  bsc_pkg::t_cal  i_cal,
    output logic           o_valid,
    output bsc_pkg::t_out  o_data
);
    import bsc_pkg::*;

    logic [5:0] r_vld;
    t_side r1_side, r2_side, r3_side, r4_side, r5_side;
    logic  r1_zero, r2_zero, r3_zero, r4_zero, r5_zero;

    logic signed [63:0] w_s;
    logic signed [49:0] r1_pp9l, r1_pp9h, r1_pp8l, r1_pp8h;
    logic        [63:0] r1_q, r1_s;

    logic        [63:0] r2_p9s, r2_p8q, r2_q, r2_s;

    logic signed [63:0] w_v2;
    logic        [63:0] r3_m0;
    logic        [31:0] r3_m1, r3_m2;
    logic        [63:0] r3_v2, r3_q;

    logic        [63:0] w_prod;
    logic signed [63:0] w_v1;
    logic        [63:0] r4_v1, r4_v2, r4_q;

    logic        [63:0] r5_sum;

    logic signed [63:0] w_sum_sh, w_p7x;
    logic        [63:0] w_pr;
    t_out               r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    assign w_s      = $signed(i_quot) >>> 13;
    assign w_v2     = $signed(r2_p8q) >>> 19;
    assign w_prod   = r3_m0 + {r3_m1 + r3_m2, 32'd0};
    assign w_v1     = $signed(w_prod) >>> 25;
    assign w_sum_sh = $signed(r5_sum) >>> 8;
    assign w_p7x    = 64'(i_cal.p7) <<< 4;
    assign w_pr     = w_sum_sh + w_p7x;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_pp9l <= mul_pp(w_s[31:0], k17(i_cal.p9));
            r1_pp9h <= mul_pp(w_s[63:32], k17(i_cal.p9));
            r1_pp8l <= mul_pp(i_quot[31:0], k17(i_cal.p8));
            r1_pp8h <= mul_pp(i_quot[63:32], k17(i_cal.p8));
            r1_q    <= i_quot;
            r1_s    <= w_s;
            r1_zero <= i_zero;
            r1_side <= i_side;

            r2_p9s  <= pp_join(r1_pp9l, r1_pp9h);
            r2_p8q  <= pp_join(r1_pp8l, r1_pp8h);
            r2_q    <= r1_q;
            r2_s    <= r1_s;
            r2_zero <= r1_zero;
            r2_side <= r1_side;

            // low 64 bits of the second product from three 32x32 pieces
            r3_m0   <= r2_p9s[31:0] * r2_s[31:0];
            r3_m1   <= 32'(r2_p9s[31:0] * r2_s[63:32]);
            r3_m2   <= 32'(r2_p9s[63:32] * r2_s[31:0]);
            r3_v2   <= w_v2;
            r3_q    <= r2_q;
            r3_zero <= r2_zero;
            r3_side <= r2_side;

            r4_v1   <= w_v1;
            r4_v2   <= r3_v2;
            r4_q    <= r3_q;
            r4_zero <= r3_zero;
            r4_side <= r3_side;

            r5_sum  <= r4_q + r4_v1 + r4_v2;
            r5_zero <= r4_zero;
            r5_side <= r4_side;

            // drop the pressure when the divisor was zero
            r_out.temperature_centi <= r5_side.temperature_centi;
            r_out.fine_temperature  <= r5_side.fine_temperature;
            r_out.pressure_q24_8    <= r5_zero ? 32'd0 : w_pr[31:0];
            r_out.pressure_valid    <= !r5_zero;
        end
    end

    assign o_valid = r_vld[5];
    assign o_data  = r_out;

endmodule

// ===== rtl/barometric_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer temperature and pressure compensation of raw 20-bit readings.
// ----------------------------------------------------------------------------
// Takes one word per clock while o_ready is high and returns one result word
// per input word, in order, through 4 temperature stages, 7 coefficient
// stages, 66 divider stages (the 64-bit quotient is resolved one bit per
// stage), 6 correction stages and the output register. The whole pipeline
// holds when a finished word waits at the output and a valid word sits in
// the last stage; bubbles inside the pipeline hold with it and do not close
// up.
// Calibration registers are taken on every config write and must only change
// while no word is in flight.
`include "barometric_sensor_compensation_macros.svh"

module barometric_sensor_compensation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  bsc_pkg::t_in                      i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output bsc_pkg::t_out                     o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import bsc_pkg::*;

    logic [31:0] r_cal_t1_t2, r_cal_t3_p1, r_cal_p2_p3;
    logic [31:0] r_cal_p4_p5, r_cal_p6_p7, r_cal_p8_p9;
    t_cal        w_cal;

    logic w_adv;

    logic               w_temp_valid;
    t_side              w_temp_side;
    logic signed [31:0] w_a0;
    logic        [19:0] w_raw_p;

    logic               w_coef_valid;
    t_side              w_coef_side;
    logic        [63:0] w_num;
    logic signed [30:0] w_den;

    logic               w_div_valid;
    t_side              w_div_side;
    logic        [63:0] w_quot;
    logic               w_zero;

    logic               w_post_valid;
    t_out               w_post_data;

    logic               r_out_valid;
    t_out               r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t1_t2 <= '0;
            r_cal_t3_p1 <= '0;
            r_cal_p2_p3 <= '0;
            r_cal_p4_p5 <= '0;
            r_cal_p6_p7 <= '0;
            r_cal_p8_p9 <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cal_idx'(i_cfg_index))
                CAL_T1_T2: r_cal_t1_t2 <= i_cfg_data;
                CAL_T3_P1: r_cal_t3_p1 <= i_cfg_data;
                CAL_P2_P3: r_cal_p2_p3 <= i_cfg_data;
                CAL_P4_P5: r_cal_p4_p5 <= i_cfg_data;
                CAL_P6_P7: r_cal_p6_p7 <= i_cfg_data;
                CAL_P8_P9: r_cal_p8_p9 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cal.t1 = r_cal_t1_t2[15:0];
    assign w_cal.t2 = r_cal_t1_t2[31:16];
    assign w_cal.t3 = r_cal_t3_p1[15:0];
    assign w_cal.p1 = r_cal_t3_p1[31:16];
    assign w_cal.p2 = r_cal_p2_p3[15:0];
    assign w_cal.p3 = r_cal_p2_p3[31:16];
    assign w_cal.p4 = r_cal_p4_p5[15:0];
    assign w_cal.p5 = r_cal_p4_p5[31:16];
    assign w_cal.p6 = r_cal_p6_p7[15:0];
    assign w_cal.p7 = r_cal_p6_p7[31:16];
    assign w_cal.p8 = r_cal_p8_p9[15:0];
    assign w_cal.p9 = r_cal_p8_p9[31:16];

    // hold everything only when the last stage cannot hand its word over
    assign w_adv   = !w_post_valid || !r_out_valid || i_ready;
    assign o_ready = w_adv;

    bsc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_cal   (w_cal),
        .o_valid (w_temp_valid),
        .o_side  (w_temp_side),
        .o_a0    (w_a0),
        .o_raw_p (w_raw_p)
    );

    bsc_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_temp_valid),
        .i_side  (w_temp_side),
        .i_a0    (w_a0),
        .i_raw_p (w_raw_p),
        .i_cal   (w_cal),
        .o_valid (w_coef_valid),
        .o_side  (w_coef_side),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_coef_valid),
        .i_side  (w_coef_side),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_valid (w_div_valid),
        .o_side  (w_div_side),
        .o_quot  (w_quot),
        .o_zero  (w_zero)
    );

    bsc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_div_valid),
        .i_side  (w_div_side),
        .i_quot  (w_quot),
        .i_zero  (w_zero),
        .i_cal   (w_cal),
        .o_valid (w_post_valid),
        .o_data  (w_post_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_post_valid && w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_post_valid && w_adv) begin
            r_out <= w_post_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `BSC_ASSERT_IMPL(a_press_zero, o_valid, o_data.pressure_valid || (o_data.pressure_q24_8 == 32'd0))
    `BSC_ASSERT_IMPL(a_temp_range, o_valid, (o_data.temperature_centi >= TEMP_MIN) && (o_data.temperature_centi <= TEMP_MAX))
    `BSC_ASSERT_IMPL(a_stall_cause, !o_ready, o_valid && !i_ready)
    `BSC_ASSERT_NEXT(a_cfg_write, i_rst_n && i_cfg_valid && (i_cfg_index == CAL_T1_T2), r_cal_t1_t2 == $past(i_cfg_data))

endmodule
